// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Holds the request and response structs, the entry layout and the command codes.
// Depends on nothing.
`default_nettype none

package spq_pkg;

	// Default number of cells in the chain.
	localparam int DEPTH_DEF = 16;

	// Width of the entry_count field in a response.
	localparam int ENTRY_COUNT_W = 5;

	// Command codes.
	typedef enum logic {
		CMD_ENQ = 1'b0,
		CMD_DEQ = 1'b1
	} cmd_t;

	// Error codes.
	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} err_t;

	// One stored entry.
	typedef struct packed {
		logic [15:0]        arrival;
		logic [15:0]        id;
		logic signed [15:0] score;
		logic [15:0]        service;
	} entry_t;

	// Request transaction.
	typedef struct packed {
		logic               cmd;
		logic [15:0]        arrival_time;
		logic [15:0]        entry_id;
		logic signed [15:0] priority_score;
		logic [15:0]        service_time;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic                     item_valid;
		logic [15:0]              out_arrival;
		logic [15:0]              out_id;
		logic signed [15:0]       out_score;
		logic [15:0]              out_service;
		logic [1:0]               error_code;
		logic [ENTRY_COUNT_W-1:0] entry_count;
	} rsp_t;

	// Operation broadcast to all cells together.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
// Depends on spq_pkg for the entry and control types.
`default_nettype none

module spq_cell
	import spq_pkg::*;
(
	input  wire logic       clk,
	input  wire cell_ctrl_t ctrl,
	input  wire entry_t     new_entry,
	input  wire logic       occ,
	input  wire logic       left_keep,
	input  wire entry_t     left_entry,
	input  wire entry_t     right_entry,
	output logic            keep,
	output entry_t          entry
);

	entry_t entry_q;

	// The stored entry stays ahead of the new one on a higher score, or on an
	// equal score with a strictly earlier arrival.
	always_comb begin
		keep = occ && ((entry_q.score > new_entry.score) ||
			((entry_q.score == new_entry.score) && (entry_q.arrival < new_entry.arrival)));
	end

	// Enqueue: hold, take the new entry at the insertion point, or shift back.
	// Dequeue: every cell takes its right neighbor's entry; the last cell takes the new entry.
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				entry_q <= left_keep ? new_entry : left_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: command control, count and the cell chain.
// Depends on spq_pkg and spq_cell.
//
//  channel | signals                   | direction | contents
//  req     | req_valid, req_ready, req | in        | command and entry (req_t)
//  rsp     | rsp_valid, rsp_ready, rsp | out       | result, error, count (rsp_t)
//
// A command is applied to every cell of the chain at the edge where it is accepted,
// unless it fails as full or empty, and its response appears in the output register
// the cycle after. A new command is taken while the previous response waits, as long
// as that response is taken in the same cycle. Reset empties the queue at once;
// no clearing pass is needed since only occupied cells are ever read.
`default_nettype none

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic             accept;
	logic             full;
	logic             empty;
	cell_ctrl_t       ctrl;
	entry_t           new_entry;
	rsp_t             rsp_n;

	entry_t           cell_entry [DEPTH];
	logic             cell_keep  [DEPTH];

	// Handshake: the output register frees up when its response is taken.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// Entry to insert.
	always_comb begin
		new_entry.arrival = req.arrival_time;
		new_entry.id      = req.entry_id;
		new_entry.score   = req.priority_score;
		new_entry.service = req.service_time;
	end

	// Decode the command, the new count and the response.
	always_comb begin
		ctrl.enq = 1'b0;
		ctrl.deq = 1'b0;
		count_n  = count_q;
		rsp_n    = '0;
		case (cmd_t'(req.cmd))
			CMD_ENQ: begin
				if (full) begin
					rsp_n.error_code = ERR_FULL;
				end else begin
					ctrl.enq = accept;
					count_n  = count_q + CNT_W'(1);
				end
			end
			CMD_DEQ: begin
				if (empty) begin
					rsp_n.error_code = ERR_EMPTY;
				end else begin
					ctrl.deq          = accept;
					count_n           = count_q - CNT_W'(1);
					rsp_n.item_valid  = 1'b1;
					rsp_n.out_arrival = cell_entry[0].arrival;
					rsp_n.out_id      = cell_entry[0].id;
					rsp_n.out_score   = cell_entry[0].score;
					rsp_n.out_service = cell_entry[0].service;
				end
			end
			default: begin
				rsp_n.error_code = ERR_OK;
			end
		endcase
		rsp_n.entry_count = ENTRY_COUNT_W'(count_n);
	end

	// Count and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The chain of cells; cell 0 is the front of the queue.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occ;
		logic   left_keep;
		entry_t left_entry;
		entry_t right_entry;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_front
			assign left_keep  = 1'b1;
			assign left_entry = new_entry;
		end else begin : g_mid
			assign left_keep  = cell_keep[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign right_entry = new_entry;
		end else begin : g_next
			assign right_entry = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.occ         (occ),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.keep        (cell_keep[i]),
			.entry       (cell_entry[i])
		);
	end

endmodule

`default_nettype wire
